/* sv/tdrp_pkg.sv */
package tdrp_pkg;

   localparam int unsigned DimWidth   = 13;
   localparam int unsigned PosWidth   = 12;
   localparam int unsigned PctWidth   = 7;
   localparam int unsigned AreaWidth  = 25;
   localparam int unsigned PixWidth   = 32;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [CsrIdxWidth-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_FULL_PERCENT = 2'd2;

   localparam logic [DimWidth-1:0] RESET_WIDTH   = 13'd640;
   localparam logic [DimWidth-1:0] RESET_HEIGHT  = 13'd480;
   localparam logic [PctWidth-1:0] RESET_PERCENT = 7'd75;

   localparam int unsigned RspDataWidth = 80;

   // result word kinds selected by the controller
   typedef enum logic [1:0] {
      OUT_NONE = 2'd0,
      OUT_FULL = 2'd1,
      OUT_RECT = 2'd2
   } out_kind_type;

   // controller -> datapath
   typedef struct packed {
      logic         pix_step;     // accepted pixel
      logic         clear_start;  // begin clearing the map
      logic         clear_step;
      logic         scan_start;   // start of rectangle pass
      logic         scan_step;    // look at one tile
      logic         merge_step;   // compare one table entry
      logic         area_start;
      logic         area_step;
      logic         thr_step;
      logic         emit_load;
      out_kind_type emit_kind;
      logic         emit_next;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic frame_end;      // the accepted pixel closed the frame
      logic clear_done;
      logic force_full;     // missing snapshot or too many tiles
      logic change_seen;
      logic scan_done;
      logic run_ready;      // a run was closed, merge pass needed
      logic merge_done;
      logic table_full;
      logic area_done;
      logic over_thr;
      logic no_rects;
      logic emit_last;
   } dp_stat_type;

endpackage

/* sv/tdrp_datapath.sv */
module tdrp_datapath #(
   parameter int unsigned TILE_WIDTH     = 32,
   parameter int unsigned TILE_HEIGHT    = 32,
   parameter int unsigned MAX_TILE_COUNT = 4096,
   parameter int unsigned MAX_RECT_COUNT = 32,
   parameter int unsigned MAX_DIMENSION  = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [tdrp_pkg::PixWidth-1:0]        cur_pix,
   input  logic [tdrp_pkg::PixWidth-1:0]        prev_pix,
   input  logic                                 no_snap,
   input  logic [tdrp_pkg::DimWidth-1:0]        cfg_width,
   input  logic [tdrp_pkg::DimWidth-1:0]        cfg_height,
   input  logic [tdrp_pkg::PctWidth-1:0]        cfg_percent,
   input  tdrp_pkg::dp_cmd_type                 cmd,
   output tdrp_pkg::dp_stat_type                stat,
   output logic [tdrp_pkg::RspDataWidth-1:0]    out_data
);
   import tdrp_pkg::*;

   localparam int unsigned TileIdxW = (MAX_TILE_COUNT > 1) ? $clog2(MAX_TILE_COUNT) : 1;
   localparam int unsigned RectIdxW = (MAX_RECT_COUNT > 1) ? $clog2(MAX_RECT_COUNT) : 1;
   localparam int unsigned RectCntW = $clog2(MAX_RECT_COUNT + 1);
   localparam int unsigned TxW      = DimWidth;   // tile counts fit the dimension width
   localparam int unsigned TileCntW = 2 * DimWidth;

   // tile counts by reciprocal multiplication, exact for every clamped size
   localparam int unsigned     RecipShift = 26;
   localparam longint unsigned RecipX =
      ((64'd1 << RecipShift) + 64'(TILE_WIDTH) - 64'd1) / 64'(TILE_WIDTH);
   localparam longint unsigned RecipY =
      ((64'd1 << RecipShift) + 64'(TILE_HEIGHT) - 64'd1) / 64'(TILE_HEIGHT);

   // clamped frame size
   logic [DimWidth-1:0] w_c, h_c;
   always_comb begin
      w_c = (cfg_width == '0) ? DimWidth'(1) :
            (32'(cfg_width) > MAX_DIMENSION) ? DimWidth'(MAX_DIMENSION) : cfg_width;
      h_c = (cfg_height == '0) ? DimWidth'(1) :
            (32'(cfg_height) > MAX_DIMENSION) ? DimWidth'(MAX_DIMENSION) : cfg_height;
   end

   logic [TxW-1:0] tx_n, ty_n;
   logic [39:0]    tx_prod, ty_prod;
   assign tx_prod = (40'(w_c) + 40'(TILE_WIDTH - 1)) * 40'(RecipX);
   assign ty_prod = (40'(h_c) + 40'(TILE_HEIGHT - 1)) * 40'(RecipY);
   assign tx_n = TxW'(tx_prod >> RecipShift);
   assign ty_n = TxW'(ty_prod >> RecipShift);

   // pixel position, kept as tile index plus offset inside the tile
   logic [DimWidth-1:0] col_ff, col_in, row_ff, row_in;
   logic [TxW-1:0]      ptx_ff, ptx_in, pty_ff, pty_in;
   logic [7:0]          offx_ff, offx_in, offy_ff, offy_in;
   logic [TileCntW-1:0] rowbase_ff, rowbase_in;  // pty * tx_n
   logic                change_ff, change_in, miss_ff, miss_in;

   logic diff, col_wrap, row_wrap, mark_ok;
   logic [TileCntW-1:0] mark_idx;
   assign diff     = cur_pix != prev_pix;
   assign col_wrap = 32'(col_ff) + 1 >= 32'(w_c);
   assign row_wrap = 32'(row_ff) + 1 >= 32'(h_c);
   assign mark_idx = rowbase_ff + TileCntW'(ptx_ff);
   assign mark_ok  = diff && (ptx_ff < tx_n) && (pty_ff < ty_n)
                     && (32'(mark_idx) < MAX_TILE_COUNT);

   always_comb begin
      col_in = col_ff; row_in = row_ff; ptx_in = ptx_ff; pty_in = pty_ff;
      offx_in = offx_ff; offy_in = offy_ff; rowbase_in = rowbase_ff;
      change_in = change_ff; miss_in = miss_ff;
      if (cmd.pix_step) begin
         if (col_ff == '0 && row_ff == '0) miss_in = no_snap;
         if (diff) change_in = 1'b1;
         if (!col_wrap) begin
            col_in = col_ff + 1'b1;
            if (32'(offx_ff) + 1 == TILE_WIDTH) begin
               offx_in = '0;
               ptx_in  = ptx_ff + 1'b1;
            end else begin
               offx_in = offx_ff + 1'b1;
            end
         end else begin
            col_in = '0; offx_in = '0; ptx_in = '0;
            if (!row_wrap) begin
               row_in = row_ff + 1'b1;
               if (32'(offy_ff) + 1 == TILE_HEIGHT) begin
                  offy_in    = '0;
                  pty_in     = pty_ff + 1'b1;
                  rowbase_in = rowbase_ff + TileCntW'(tx_n);
               end else begin
                  offy_in = offy_ff + 1'b1;
               end
            end else begin
               row_in = '0; offy_in = '0; pty_in = '0; rowbase_in = '0;
            end
         end
      end
      if (cmd.clear_start) begin
         change_in = 1'b0; miss_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0; ptx_ff <= '0; pty_ff <= '0;
         offx_ff <= '0; offy_ff <= '0; rowbase_ff <= '0;
         change_ff <= 1'b0; miss_ff <= 1'b0;
      end else begin
         col_ff <= col_in; row_ff <= row_in; ptx_ff <= ptx_in; pty_ff <= pty_in;
         offx_ff <= offx_in; offy_ff <= offy_in; rowbase_ff <= rowbase_in;
         change_ff <= change_in; miss_ff <= miss_in;
      end
   end

   // tile map memory: one write port, one registered read port
   logic                map_mem [MAX_TILE_COUNT];
   logic [TileIdxW-1:0] clr_ff, clr_in;
   logic                clr_last;
   logic [TileIdxW-1:0] scan_addr;
   logic                map_rd_ff;
   assign clr_last = 32'(clr_ff) == MAX_TILE_COUNT - 1;
   always_comb begin
      clr_in = clr_ff;
      if (cmd.clear_start) clr_in = '0;
      else if (cmd.clear_step) clr_in = clr_last ? '0 : clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else       clr_ff <= clr_in;
   end

   // the read data holds the current tile while the scan waits on a merge
   always_ff @(posedge clock) begin
      if (cmd.clear_step)
         map_mem[clr_ff] <= 1'b0;
      else if (cmd.pix_step && mark_ok)
         map_mem[TileIdxW'(mark_idx)] <= 1'b1;
      if (cmd.scan_start || cmd.scan_step)
         map_rd_ff <= map_mem[scan_addr];
   end

   // scan: tx/ty walk, the read of tile (tx,ty) is issued by the preceding scan step into map_rd_ff
   logic [TxW-1:0]      stx_ff, stx_in, sty_ff, sty_in;
   logic [TileCntW-1:0] sidx_ff, sidx_in;
   logic                in_run_ff, in_run_in;
   logic [TxW-1:0]      rs_ff, rs_in;
   logic                run_ready_ff, run_ready_in;
   logic [TxW-1:0]      run_s_ff, run_s_in, run_e_ff, run_e_in, run_ty_ff, run_ty_in;
   logic                scan_done_ff, scan_done_in;
   logic                row_end;
   logic                tile_bit;

   assign scan_addr = TileIdxW'(cmd.scan_start ? '0 : sidx_ff);
   assign tile_bit  = map_rd_ff;
   assign row_end   = stx_ff + 1'b1 == tx_n;

   // the scan is advanced only while no closed run waits for merging
   always_comb begin
      stx_in = stx_ff; sty_in = sty_ff; sidx_in = sidx_ff;
      in_run_in = in_run_ff; rs_in = rs_ff;
      run_ready_in = run_ready_ff; run_s_in = run_s_ff; run_e_in = run_e_ff;
      run_ty_in = run_ty_ff; scan_done_in = scan_done_ff;
      if (cmd.scan_start) begin
         stx_in = '0; sty_in = '0; sidx_in = TileCntW'(1);
         in_run_in = 1'b0; run_ready_in = 1'b0; scan_done_in = 1'b0;
      end else if (cmd.merge_step && stat.merge_done) begin
         run_ready_in = 1'b0;
      end else if (cmd.scan_step) begin
         sidx_in = sidx_ff + 1'b1;
         if (tile_bit && !in_run_ff) begin
            in_run_in = 1'b1;
            rs_in     = stx_ff;
         end
         if (in_run_ff && !tile_bit) begin
            in_run_in = 1'b0;
            run_ready_in = 1'b1; run_s_in = rs_ff; run_e_in = stx_ff; run_ty_in = sty_ff;
         end
         if (row_end) begin
            if (tile_bit) begin
               in_run_in = 1'b0;
               run_ready_in = 1'b1;
               run_s_in = in_run_ff ? rs_ff : stx_ff;
               run_e_in = tx_n; run_ty_in = sty_ff;
            end
            stx_in = '0;
            sty_in = sty_ff + 1'b1;
            if (sty_ff + 1'b1 == ty_n) scan_done_in = 1'b1;
         end else begin
            stx_in = stx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stx_ff <= '0; sty_ff <= '0; sidx_ff <= '0; in_run_ff <= 1'b0;
         run_ready_ff <= 1'b0; scan_done_ff <= 1'b0;
      end else begin
         stx_ff <= stx_in; sty_ff <= sty_in; sidx_ff <= sidx_in; in_run_ff <= in_run_in;
         run_ready_ff <= run_ready_in; scan_done_ff <= scan_done_in;
      end
      rs_ff <= rs_in; run_s_ff <= run_s_in; run_e_ff <= run_e_in; run_ty_ff <= run_ty_in;
   end

   // run geometry, combinational from the registered run fields (stable during merge)
   logic [TileCntW-1:0] x_w, right_w, y_w, bot_w;
   logic [DimWidth-1:0] nx, ny, nw, nh;
   assign x_w     = TileCntW'(run_s_ff) * TileCntW'(TILE_WIDTH);
   assign right_w = TileCntW'(run_e_ff) * TileCntW'(TILE_WIDTH);
   assign y_w     = TileCntW'(run_ty_ff) * TileCntW'(TILE_HEIGHT);
   assign bot_w   = y_w + TileCntW'(TILE_HEIGHT);
   assign nx = DimWidth'(x_w);
   assign ny = DimWidth'(y_w);
   assign nw = DimWidth'(((right_w > TileCntW'(w_c)) ? TileCntW'(w_c) : right_w) - x_w);
   assign nh = DimWidth'(((bot_w > TileCntW'(h_c)) ? TileCntW'(h_c) : bot_w) - y_w);

   // rect table: x, y, w, h; small array walked one entry per cycle
   logic [DimWidth-1:0] rx_mem [MAX_RECT_COUNT];
   logic [DimWidth-1:0] ry_mem [MAX_RECT_COUNT];
   logic [DimWidth-1:0] rw_mem [MAX_RECT_COUNT];
   logic [DimWidth-1:0] rh_mem [MAX_RECT_COUNT];
   logic [RectCntW-1:0] rcnt_ff, rcnt_in, mi_ff, mi_in;
   logic [RectIdxW-1:0] mi_idx;
   logic                hit, m_end;
   assign mi_idx = mi_ff[RectIdxW-1:0];
   assign m_end  = mi_ff == rcnt_ff;
   assign hit    = !m_end && rx_mem[mi_idx] == nx && rw_mem[mi_idx] == nw
                   && (14'(ry_mem[mi_idx]) + 14'(rh_mem[mi_idx]) == 14'(ny));

   always_comb begin
      rcnt_in = rcnt_ff; mi_in = mi_ff;
      if (cmd.scan_start) begin
         rcnt_in = '0; mi_in = '0;
      end else if (cmd.merge_step) begin
         if (hit) mi_in = '0;
         else if (m_end) begin
            mi_in = '0;
            if (32'(rcnt_ff) < MAX_RECT_COUNT) rcnt_in = rcnt_ff + 1'b1;
         end else mi_in = mi_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rcnt_ff <= '0; mi_ff <= '0;
      end else begin
         rcnt_ff <= rcnt_in; mi_ff <= mi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.merge_step) begin
         if (hit)
            rh_mem[mi_idx] <= DimWidth'(14'(ny) + 14'(nh) - 14'(ry_mem[mi_idx]));
         else if (m_end && 32'(rcnt_ff) < MAX_RECT_COUNT) begin
            rx_mem[RectIdxW'(rcnt_ff)] <= nx;
            ry_mem[RectIdxW'(rcnt_ff)] <= ny;
            rw_mem[RectIdxW'(rcnt_ff)] <= nw;
            rh_mem[RectIdxW'(rcnt_ff)] <= nh;
         end
      end
   end

   // area sum: one product per cycle through a registered multiplier
   logic [RectCntW-1:0]  ai_ff, ai_in;
   logic [AreaWidth-1:0] prod_ff, area_ff, area_in;
   logic                 pv_ff, pv_in;
   logic                 a_end;
   assign a_end = ai_ff == rcnt_ff;
   always_comb begin
      ai_in = ai_ff; area_in = area_ff; pv_in = 1'b0;
      if (cmd.area_start) begin
         ai_in = '0; area_in = '0;
      end else if (cmd.area_step) begin
         if (pv_ff) area_in = area_ff + prod_ff;
         if (!a_end) begin
            ai_in = ai_ff + 1'b1; pv_in = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         ai_ff <= '0; area_ff <= '0; pv_ff <= 1'b0;
      end else begin
         ai_ff <= ai_in; area_ff <= area_in; pv_ff <= pv_in;
      end
      prod_ff <= AreaWidth'(rw_mem[ai_ff[RectIdxW-1:0]]) *
                 AreaWidth'(rh_mem[ai_ff[RectIdxW-1:0]]);
   end

   // threshold: area*100 vs w*h*pct, two registered product steps
   logic [AreaWidth-1:0] wh_ff;
   logic [AreaWidth+6:0] lhs_ff;
   logic [AreaWidth+6:0] rhs_ff;
   always_ff @(posedge clock) begin
      wh_ff  <= AreaWidth'(w_c) * AreaWidth'(h_c);
      lhs_ff <= (AreaWidth+7)'(area_ff) * (AreaWidth+7)'(100);
      if (cmd.thr_step) rhs_ff <= (AreaWidth+7)'(wh_ff) * (AreaWidth+7)'(cfg_percent);
   end

   // output word: last at the top, data fields from bit 0 up
   logic [RectCntW-1:0] oi_ff, oi_in;
   logic [RspDataWidth-1:0] od_ff, od_in;
   logic [RectIdxW-1:0] oidx;
   assign oidx = oi_in[RectIdxW-1:0];
   always_comb begin
      oi_in = oi_ff;
      if (cmd.emit_load) oi_in = '0;
      else if (cmd.emit_next) oi_in = oi_ff + 1'b1;
   end
   always_ff @(posedge clock) begin
      if (reset) oi_ff <= '0;
      else       oi_ff <= oi_in;
   end
   always_comb begin
      od_in = od_ff;
      if (cmd.emit_load || cmd.emit_next) begin
         unique case (cmd.emit_kind)
            OUT_FULL: od_in = {1'b1, 2'b0, wh_ff, h_c, w_c, 12'd0, 12'd0, 1'b1, 1'b1};
            OUT_RECT: od_in = {1'b0, 2'b0, area_ff, rh_mem[oidx], rw_mem[oidx],
                               ry_mem[oidx][PosWidth-1:0], rx_mem[oidx][PosWidth-1:0],
                               1'b0, 1'b1};
            default:  od_in = {1'b1, 79'd0};
         endcase
         od_in[79] = (cmd.emit_kind != OUT_RECT) || (oi_in + 1'b1 == rcnt_ff);
      end
   end
   always_ff @(posedge clock) od_ff <= od_in;
   assign out_data = od_ff;

   // full-frame wh value must match a clamped 4096x4096 exactly
   always_comb begin
      stat.frame_end  = col_wrap && row_wrap;
      stat.clear_done = clr_last;
      stat.force_full = miss_ff || (32'(tx_n) * 32'(ty_n) > MAX_TILE_COUNT);
      stat.change_seen = change_ff;
      stat.scan_done  = scan_done_ff;
      stat.run_ready  = run_ready_ff;
      stat.merge_done = hit || m_end;
      stat.table_full = m_end && !hit && 32'(rcnt_ff) >= MAX_RECT_COUNT;
      stat.area_done  = a_end && !pv_ff;
      stat.over_thr   = lhs_ff >= rhs_ff;
      stat.no_rects   = rcnt_ff == '0;
      stat.emit_last  = oi_ff + 1'b1 >= rcnt_ff;
   end

endmodule

/* sv/tdrp_ctrl.sv */
module tdrp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tdrp_pkg::dp_cmd_type  cmd,
   input  tdrp_pkg::dp_stat_type stat
);
   import tdrp_pkg::*;

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b0000000001,
      ST_PIX   = 10'b0000000010,
      ST_SCAN0 = 10'b0000000100,
      ST_SCAN  = 10'b0000001000,
      ST_MERGE = 10'b0000010000,
      ST_AREA  = 10'b0000100000,
      ST_THR0  = 10'b0001000000,
      ST_THR   = 10'b0010000000,
      ST_DEC   = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type    st_ff, st_in;
   out_kind_type kind_ff, kind_in;
   logic         ov_ff, ov_in;
   logic         clr_go_ff, clr_go_in;

   assign in_ready  = st_ff == ST_PIX;
   assign out_valid = ov_ff;

   always_comb begin
      st_in = st_ff; kind_in = kind_ff; ov_in = ov_ff; clr_go_in = 1'b0;
      cmd = '0;
      cmd.emit_kind = kind_ff;
      unique case (st_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) st_in = ST_PIX;
         end
         ST_PIX: begin
            if (in_valid) begin
               cmd.pix_step = 1'b1;
               if (stat.frame_end) st_in = ST_SCAN0;
            end
         end
         ST_SCAN0: begin
            if (stat.force_full) begin
               kind_in = OUT_FULL; st_in = ST_DEC;
            end else if (!stat.change_seen) begin
               kind_in = OUT_NONE; st_in = ST_DEC;
            end else begin
               cmd.scan_start = 1'b1; st_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.run_ready) st_in = ST_MERGE;
            else if (stat.scan_done) begin
               cmd.area_start = 1'b1; st_in = ST_AREA;
            end else cmd.scan_step = 1'b1;
         end
         ST_MERGE: begin
            if (stat.table_full) begin
               kind_in = OUT_FULL; st_in = ST_DEC;
            end else begin
               cmd.merge_step = 1'b1;
               if (stat.merge_done) st_in = ST_SCAN;
            end
         end
         ST_AREA: begin
            cmd.area_step = 1'b1;
            if (stat.area_done) st_in = ST_THR0;
         end
         ST_THR0: begin
            cmd.thr_step = 1'b1; st_in = ST_THR;
         end
         ST_THR: begin
            if (stat.over_thr) kind_in = OUT_FULL;
            else if (stat.no_rects) kind_in = OUT_NONE;
            else kind_in = OUT_RECT;
            st_in = ST_DEC;
         end
         ST_DEC: begin
            cmd.emit_load = 1'b1; ov_in = 1'b1; st_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_ready) begin
               if (kind_ff != OUT_RECT || stat.emit_last) begin
                  ov_in = 1'b0; clr_go_in = 1'b1; st_in = ST_CLEAR;
               end else cmd.emit_next = 1'b1;
            end
         end
         default: st_in = ST_CLEAR;
      endcase
      cmd.clear_start = clr_go_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR; kind_ff <= OUT_NONE; ov_ff <= 1'b0; clr_go_ff <= 1'b1;
      end else begin
         st_ff <= st_in; kind_ff <= kind_in; ov_ff <= ov_in; clr_go_ff <= clr_go_in;
      end
   end

endmodule

/* sv/tile_damage_rect_planner_core.sv */
// Tile damage planner. Pixel pairs enter one word per clock in raster order,
// while the core is ready, and each differing pixel marks its tile in an
// on-chip tile map. After the last pixel the core walks the map one tile per
// cycle, pausing to merge each closed run into the rectangle table (one table
// entry compared per cycle), sums the area with one multiply per cycle and
// emits the rectangles, one full-frame word or one no-damage word, tlast on the
// final one. The map is cleared after each frame and after reset by a pass over
// all MAX_TILE_COUNT entries during which no pixel is accepted.
module tile_damage_rect_planner_core #(
   parameter int unsigned TILE_WIDTH     = 32,
   parameter int unsigned TILE_HEIGHT    = 32,
   parameter int unsigned MAX_TILE_COUNT = 4096,
   parameter int unsigned MAX_RECT_COUNT = 32,
   parameter int unsigned MAX_DIMENSION  = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // current_pixel, previous_pixel
   input  logic        req_tuser,   // no_snapshot
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // any_damage, whole_frame, rect_x, rect_y,
                                    // rect_w, rect_h, damage_area, zero pad
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import tdrp_pkg::*;

   logic [DimWidth-1:0] width_ff, height_ff;
   logic [PctWidth-1:0] pct_ff;
   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [RspDataWidth-1:0] od;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RESET_WIDTH; height_ff <= RESET_HEIGHT; pct_ff <= RESET_PERCENT;
      end else if (csr_we) begin
         if (csr_index == CSR_FRAME_WIDTH)  width_ff  <= csr_wdata;
         if (csr_index == CSR_FRAME_HEIGHT) height_ff <= csr_wdata;
         if (csr_index == CSR_FULL_PERCENT) pct_ff    <= csr_wdata[PctWidth-1:0];
      end
   end

   tdrp_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .cmd, .stat
   );

   tdrp_datapath #(
      .TILE_WIDTH(TILE_WIDTH), .TILE_HEIGHT(TILE_HEIGHT),
      .MAX_TILE_COUNT(MAX_TILE_COUNT), .MAX_RECT_COUNT(MAX_RECT_COUNT),
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_dp (
      .clock, .reset,
      .cur_pix(req_tdata[31:0]), .prev_pix(req_tdata[63:32]), .no_snap(req_tuser),
      .cfg_width(width_ff), .cfg_height(height_ff), .cfg_percent(pct_ff),
      .cmd, .stat, .out_data(od)
   );

   assign rsp_tdata = {3'b0, od[76:0]};
   assign rsp_tlast = od[79];

endmodule
